// ===== rtl/core/id3_pkg.sv =====
// Shared types and constants for the ID3v2 tag frame extractor.
// No dependencies; used by every module in rtl/core.
package id3_pkg;

    localparam int unsigned HDR_LEN = 10;
    localparam logic [3:0] HDR_LAST = 4'(HDR_LEN - 1);
    localparam logic [7:0] PRINT_LOW = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;
    localparam logic [27:0] POS_MAX = 28'h0FFF_FFFF;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_TARGET = 1'b1;

    typedef struct packed {
        logic [31:0] frame_id;
        logic [7:0]  content_byte;
        logic        printable;
        logic        last_of_frame;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
    } id3_result_t;

endpackage

// ===== rtl/core/id3_parse.sv =====
// Byte-wise parser: tag header, frame headers and frame content.
// Depends on id3_pkg for constants and the result struct.
module id3_parse (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic [7:0]                data_byte,
    input  logic                      start_of_file,
    input  logic                      mode,
    input  logic [31:0]               target_frame_id,
    output logic                      res_valid,
    output id3_pkg::id3_result_t      res_data
);

    localparam logic [1:0] PH_TAG_HDR = 2'd0;
    localparam logic [1:0] PH_FRM_HDR = 2'd1;
    localparam logic [1:0] PH_CONTENT = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]  phase_reg, phase_next, phase_cur;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next, hdr_cnt_cur, hdr_cnt_inc;
    logic [27:0] tag_size_reg, tag_size_next, tag_size_cur;
    logic [27:0] tag_pos_reg, tag_pos_next, tag_pos_cur, tag_pos_adv;
    logic [3:0]  frm_cnt_reg, frm_cnt_next, frm_cnt_cur, frm_cnt_inc;
    logic [31:0] id_shift_reg, id_shift_next, id_shift_cur;
    logic [31:0] size_shift_reg, size_shift_next, size_shift_cur;
    logic [31:0] remain_reg, remain_next, remain_cur;
    logic        selected_reg, selected_next, selected_cur;
    logic [7:0]  major_reg, major_next, major_cur;
    logic [7:0]  minor_reg, minor_next, minor_cur;

    // Restart the parse on a start mark, then treat the byte as header byte 0.
    always_comb begin
        phase_cur      = start_of_file ? PH_TAG_HDR : phase_reg;
        hdr_cnt_cur    = start_of_file ? '0 : hdr_cnt_reg;
        tag_size_cur   = start_of_file ? '0 : tag_size_reg;
        tag_pos_cur    = start_of_file ? '0 : tag_pos_reg;
        frm_cnt_cur    = start_of_file ? '0 : frm_cnt_reg;
        id_shift_cur   = start_of_file ? '0 : id_shift_reg;
        size_shift_cur = start_of_file ? '0 : size_shift_reg;
        remain_cur     = start_of_file ? '0 : remain_reg;
        selected_cur   = start_of_file ? 1'b0 : selected_reg;
        major_cur      = start_of_file ? '0 : major_reg;
        minor_cur      = start_of_file ? '0 : minor_reg;
    end

    assign hdr_cnt_inc = hdr_cnt_cur + 4'd1;
    assign frm_cnt_inc = frm_cnt_cur + 4'd1;
    assign tag_pos_adv = (tag_pos_cur == id3_pkg::POS_MAX) ? tag_pos_cur
                                                            : tag_pos_cur + 28'd1;

    always_comb begin
        phase_next      = phase_cur;
        hdr_cnt_next    = hdr_cnt_cur;
        tag_size_next   = tag_size_cur;
        tag_pos_next    = tag_pos_cur;
        frm_cnt_next    = frm_cnt_cur;
        id_shift_next   = id_shift_cur;
        size_shift_next = size_shift_cur;
        remain_next     = remain_cur;
        selected_next   = selected_cur;
        major_next      = major_cur;
        minor_next      = minor_cur;
        res_valid       = 1'b0;

        case (phase_cur)
            PH_TAG_HDR: begin
                if (hdr_cnt_cur == 4'd3) begin
                    major_next = data_byte;
                end else if (hdr_cnt_cur == 4'd4) begin
                    minor_next = data_byte;
                end else if (hdr_cnt_cur >= 4'd6) begin
                    tag_size_next = {tag_size_cur[20:0], data_byte[6:0]};
                end
                hdr_cnt_next = hdr_cnt_inc;
                if (hdr_cnt_cur == id3_pkg::HDR_LAST) begin
                    hdr_cnt_next = '0;
                    tag_pos_next = '0;
                    frm_cnt_next = '0;
                    phase_next   = (tag_size_next == '0) ? PH_DONE : PH_FRM_HDR;
                end
            end
            PH_FRM_HDR: begin
                if (frm_cnt_cur == '0 && tag_pos_cur >= tag_size_cur) begin
                    phase_next = PH_DONE;
                end else if (frm_cnt_cur < 4'd4 && data_byte == '0) begin
                    tag_pos_next = tag_pos_adv;
                    phase_next   = PH_DONE;
                end else begin
                    tag_pos_next = tag_pos_adv;
                    if (frm_cnt_cur < 4'd4) begin
                        id_shift_next = {id_shift_cur[23:0], data_byte};
                    end else if (frm_cnt_cur < 4'd8) begin
                        size_shift_next = {size_shift_cur[23:0], data_byte};
                    end
                    frm_cnt_next = frm_cnt_inc;
                    if (frm_cnt_cur == id3_pkg::HDR_LAST) begin
                        frm_cnt_next  = '0;
                        remain_next   = size_shift_cur;
                        selected_next = !mode || (id_shift_cur == target_frame_id);
                        phase_next    = (size_shift_cur == '0) ? PH_FRM_HDR : PH_CONTENT;
                    end
                end
            end
            PH_CONTENT: begin
                tag_pos_next = tag_pos_adv;
                res_valid    = selected_cur;
                remain_next  = remain_cur - 32'd1;
                if (remain_cur == 32'd1) begin
                    phase_next = PH_FRM_HDR;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_data.frame_id      = id_shift_cur;
        res_data.content_byte  = data_byte;
        res_data.printable     = data_byte inside {[id3_pkg::PRINT_LOW:id3_pkg::PRINT_HIGH]};
        res_data.last_of_frame = (remain_cur == 32'd1);
        res_data.version_major = major_cur;
        res_data.version_minor = minor_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_TAG_HDR;
            hdr_cnt_reg    <= '0;
            tag_size_reg   <= '0;
            tag_pos_reg    <= '0;
            frm_cnt_reg    <= '0;
            id_shift_reg   <= '0;
            size_shift_reg <= '0;
            remain_reg     <= '0;
            selected_reg   <= 1'b0;
            major_reg      <= '0;
            minor_reg      <= '0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            tag_size_reg   <= tag_size_next;
            tag_pos_reg    <= tag_pos_next;
            frm_cnt_reg    <= frm_cnt_next;
            id_shift_reg   <= id_shift_next;
            size_shift_reg <= size_shift_next;
            remain_reg     <= remain_next;
            selected_reg   <= selected_next;
            major_reg      <= major_next;
            minor_reg      <= minor_next;
        end
    end

endmodule

// ===== rtl/core/id3_out.sv =====
// Result register with a skid stage so the input side keeps moving
// while a result waits. Depends on id3_pkg for the result struct.
module id3_out (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  id3_pkg::id3_result_t      in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    output id3_pkg::id3_result_t      out_data,
    input  logic                      out_ready
);

    logic                 main_valid_reg, main_valid_next;
    id3_pkg::id3_result_t main_data_reg, main_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    id3_pkg::id3_result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_data_next  = in_data;
            end
        end else if (in_valid) begin
            // hold the stalled result, park the new one
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/core/id3_tag_frame_extractor.sv =====
// ID3v2 tag frame extractor top level: one file byte per request in, one
// content byte of a selected frame per request out.
// A result reaches m_valid through the id3_out skid stage registers.
// Throughput: one byte per cycle while s_ready is high (skid stage empty).
// Reset (aresetn low, synchronous) clears mode, target ID and the parse state.
// Depends on id3_pkg, id3_parse and id3_out.
module id3_tag_frame_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_frame_id,
    output logic [7:0]  m_content_byte,
    output logic        m_printable,
    output logic        m_last_of_frame,
    output logic [7:0]  m_version_major,
    output logic [7:0]  m_version_minor
);

    logic                 mode_reg;
    logic [31:0]          target_reg;
    logic                 accept;
    logic                 res_valid;
    id3_pkg::id3_result_t res_data;
    id3_pkg::id3_result_t out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            target_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                id3_pkg::CFG_MODE: begin
                    mode_reg <= cfg_wr_data[0];
                end
                id3_pkg::CFG_TARGET: begin
                    target_reg <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    id3_parse u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .data_byte       (s_data_byte),
        .start_of_file   (s_start_of_file),
        .mode            (mode_reg),
        .target_frame_id (target_reg),
        .res_valid       (res_valid),
        .res_data        (res_data)
    );

    id3_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_data   (res_data),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    assign m_frame_id      = out_data.frame_id;
    assign m_content_byte  = out_data.content_byte;
    assign m_printable     = out_data.printable;
    assign m_last_of_frame = out_data.last_of_frame;
    assign m_version_major = out_data.version_major;
    assign m_version_minor = out_data.version_minor;

endmodule
